// ----- rtl/core/ptd_pkg.sv -----
// Package for the trial-division primality test.
// Shared widths, defaults and the control/status structs of the remainder unit.
// No dependencies.
`default_nettype none

package ptd_pkg;

  localparam int WidthDef = 16;  // default working width of the test
  localparam int CandW    = 16;  // width of the candidate field on the port

  typedef struct packed {
    logic start;      // load dividend and divisor, begin a remainder pass
  } rem_ctrl_t;

  typedef struct packed {
    logic done;       // one-cycle pulse at the end of a pass
    logic zero;       // remainder is zero, valid while done is high
  } rem_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ptd_if.sv -----
// Stream interfaces of the primality test: candidate in, verdict out.
// Depends on ptd_pkg for the candidate width.
`default_nettype none

interface ptd_cand_if import ptd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CandW-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface ptd_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ptd_rem.sv -----
// Shared remainder unit: restoring division, one dividend bit per cycle.
// Depends on ptd_pkg for the control and status structs.
`default_nettype none

module ptd_rem import ptd_pkg::*; #(
  parameter int Width = WidthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rem_ctrl_t        ctrl_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output rem_stat_t             stat_o
);

  localparam int CntW = $clog2(Width + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [Width-1:0] nsh_q, nsh_d;
  logic [Width-1:0] rem_q, rem_d;
  logic [Width-1:0] dsr_q, dsr_d;
  logic [Width:0]   rem_sh;
  logic [Width:0]   rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_q, nsh_q[Width-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    fits    = rem_sh >= {1'b0, dsr_q};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    nsh_d  = nsh_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;

    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(Width);
      nsh_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when the divisor fits
      nsh_d = {nsh_q[Width-2:0], 1'b0};
      rem_d = fits ? rem_sub[Width-1:0] : rem_sh[Width-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nsh_q <= nsh_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.zero = (rem_q == '0);

endmodule

`default_nettype wire

// ----- rtl/core/prime_trial_division_test.sv -----
// Trial-division primality test. At most floor(sqrt(n))-1 divisors are tried, 2 up to
// floor(sqrt(n)). Each divisor costs a compare in S_CHECK and a pass on the shared
// remainder unit, ending in the S_DIV state that sees its done pulse. One candidate
// at a time: ready only while idle; the verdict waits in an output register, so the
// next candidate may enter before it is taken.
// Reset (async, active low) clears the sequencer and the output valid.
`default_nettype none

module prime_trial_division_test import ptd_pkg::*; #(
  parameter int Width = WidthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ptd_cand_if.sink  cand_i,
  ptd_res_if.source res_o
);

  localparam int SqW = Width + 2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic             ov_q, ov_d;
  logic             res_q, res_d;
  logic             verdict_q, verdict_d;
  logic [Width-1:0] n_q, n_d;
  logic [Width-1:0] d_q, d_d;
  logic [SqW-1:0]   sq_q, sq_d;
  rem_ctrl_t        rem_ctrl;
  rem_stat_t        rem_stat;
  logic             small_n;
  logic             past_root;

  ptd_rem #(.Width(Width)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (rem_ctrl),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .stat_o     (rem_stat)
  );

  assign cand_i.ready   = (state_q == S_IDLE);
  assign res_o.valid    = ov_q;
  assign res_o.is_prime = res_q;

  always_comb begin
    small_n   = n_q < Width'(2);
    past_root = sq_q > SqW'(n_q);

    state_d   = state_q;
    ov_d      = ov_q;
    res_d     = res_q;
    verdict_d = verdict_q;
    n_d       = n_q;
    d_d       = d_q;
    sq_d      = sq_q;
    rem_ctrl.start = 1'b0;

    // drop the output beat once taken
    if (ov_q && res_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cand_i.valid) begin
          n_d     = Width'(cand_i.candidate);
          d_d     = Width'(2);
          sq_d    = SqW'(4);
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (small_n) begin
          verdict_d = 1'b0;
          state_d   = S_DONE;
        end else if (past_root) begin
          verdict_d = 1'b1;
          state_d   = S_DONE;
        end else begin
          rem_ctrl.start = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            verdict_d = 1'b0;
            state_d   = S_DONE;
          end else begin
            // advance: (d+1)^2 = d^2 + 2d + 1
            d_d     = d_q + Width'(1);
            sq_d    = sq_q + SqW'({d_q, 1'b1});
            state_d = S_CHECK;
          end
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!ov_q || res_o.ready) begin
          ov_d    = 1'b1;
          res_d   = verdict_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    verdict_q <= verdict_d;
    n_q       <= n_d;
    d_q       <= d_d;
    sq_q      <= sq_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/ptd_checker.sv -----
// Port-level checker for the primality test, bound to the top level.
// Depends on ptd_pkg for the candidate width and on prime_trial_division_test's ports.
`default_nettype none

module ptd_checker import ptd_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             cand_valid_i,
  input wire logic             cand_ready_i,
  input wire logic [CandW-1:0] candidate_i,
  input wire logic             res_valid_i,
  input wire logic             res_ready_i,
  input wire logic             is_prime_i
);

  // a stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(is_prime_i))
    else $error("result verdict changed while stalled");

  // the block is busy right after taking a candidate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_valid_i && cand_ready_i |=> !cand_ready_i)
    else $error("ready right after accepting a candidate");

  // a new verdict appears only from a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(!cand_ready_i))
    else $error("verdict appeared while idle");

  // a waiting candidate beat holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_valid_i && !cand_ready_i |=> cand_valid_i && $stable(candidate_i))
    else $error("candidate changed while waiting");

endmodule

bind prime_trial_division_test ptd_checker u_ptd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cand_valid_i (cand_i.valid),
  .cand_ready_i (cand_i.ready),
  .candidate_i  (cand_i.candidate),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .is_prime_i   (res_o.is_prime)
);

`default_nettype wire
